// ===== src/timer_slot_table_defines.svh =====
// assertion macros used by the timer slot table checker
`ifndef TIMER_SLOT_TABLE_DEFINES_SVH
`define TIMER_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, quiet during reset
`define TST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer_slot_table check failed");

// next-cycle implication, sampled on the rising clock, quiet during reset
`define TST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer_slot_table check failed");

`endif

// ===== src/tst_pkg.sv =====
// shared constants, codes and types of the timer slot table
package tst_pkg;

   // table size and derived widths
   localparam int TIMER_SLOTS = 32;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

   // most slots that may fire on one tick
   localparam int MAX_FIRE = 32;
   localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

   // field widths
   localparam int TIME_W     = 32;
   localparam int SPAN_W     = 16;
   localparam int TAG_W      = 16;
   localparam int KIND_W     = 2;
   localparam int SLOT_OUT_W = 5;

   // request code
   localparam logic REQ_TICK = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ADD_OK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd3;

   // one slot entry as kept in the slot ram
   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [SPAN_W-1:0] span;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic             take;
      logic             tick_start;
      logic [CNT_W-1:0] idx;
      logic             ram_rd;
      logic             add_commit;
      logic             emit_full;
      logic             fire_commit;
      logic             finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic new_is_tick;
      logic slot_busy;
      logic fire;
      logic out_free;
      logic pend_vld;
   } stat_type;

endpackage

// ===== src/tst_ram.sv =====
// generic single write, single read ram with registered read data
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tst_ctrl.sv =====
// controller state machine of the timer slot table: add search and tick scan
module tst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tst_pkg::stat_type  stat,
   output tst_pkg::cmd_type   cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ADD_SCAN  = 3'd1;
   localparam logic [2:0] S_TICK_SCAN = 3'd2;
   localparam logic [2:0] S_TICK_EVAL = 3'd3;
   localparam logic [2:0] S_FINISH    = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [tst_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [tst_pkg::FIRE_W-1:0]   fire_cnt_ff, fire_cnt_in;
   logic                         idx_end;
   logic                         fire_cap;

   assign idx_end  = (idx_ff == tst_pkg::CNT_W'(tst_pkg::TIMER_SLOTS));
   assign fire_cap = (fire_cnt_ff == tst_pkg::FIRE_W'(tst_pkg::MAX_FIRE));

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      fire_cnt_in = fire_cnt_ff;
      cmd         = '0;
      cmd.idx     = idx_ff;
      req_stall   = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               idx_in   = '0;
               if (stat.new_is_tick) begin
                  cmd.tick_start = 1'b1;
                  fire_cnt_in    = '0;
                  state_in       = S_TICK_SCAN;
               end else begin
                  state_in = S_ADD_SCAN;
               end
            end
         end
         S_ADD_SCAN: begin
            if (idx_end) begin
               if (stat.out_free) begin
                  cmd.emit_full = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (!stat.slot_busy) begin
               if (stat.out_free) begin
                  cmd.add_commit = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + tst_pkg::CNT_W'(1);
            end
         end
         S_TICK_SCAN: begin
            if (idx_end || fire_cap) begin
               state_in = S_FINISH;
            end else if (stat.slot_busy) begin
               cmd.ram_rd = 1'b1;
               state_in   = S_TICK_EVAL;
            end else begin
               idx_in = idx_ff + tst_pkg::CNT_W'(1);
            end
         end
         S_TICK_EVAL: begin
            if (!stat.fire) begin
               idx_in   = idx_ff + tst_pkg::CNT_W'(1);
               state_in = S_TICK_SCAN;
            end else if (!stat.pend_vld || stat.out_free) begin
               // held beat goes out as not last, this one is held
               cmd.fire_commit = 1'b1;
               fire_cnt_in     = fire_cnt_ff + tst_pkg::FIRE_W'(1);
               idx_in          = idx_ff + tst_pkg::CNT_W'(1);
               state_in        = S_TICK_SCAN;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         fire_cnt_ff <= fire_cnt_in;
      end
   end

endmodule

// ===== src/tst_dp.sv =====
// datapath of the timer slot table: slot flags, slot ram, time, held and output beats
module tst_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_type,
   input  logic [tst_pkg::SPAN_W-1:0]        req_span_ticks,
   input  logic                              req_periodic,
   input  logic [tst_pkg::TAG_W-1:0]         req_timer_tag,
   input  tst_pkg::cmd_type                  cmd,
   output tst_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tst_pkg::KIND_W-1:0]        rsp_kind,
   output logic [tst_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   output logic [tst_pkg::TAG_W-1:0]         rsp_fired_tag,
   output logic                              rsp_last
);

   logic [tst_pkg::SLOT_W-1:0]      slot;
   logic [tst_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [tst_pkg::SPAN_W-1:0]      span_ff;
   logic                            periodic_ff;
   logic [tst_pkg::TAG_W-1:0]       tag_ff;
   logic [tst_pkg::TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [tst_pkg::TIMER_SLOTS-1:0] slot_per_ff, slot_per_in;
   logic                            pend_vld_ff, pend_vld_in;
   logic [tst_pkg::SLOT_W-1:0]      pend_idx_ff;
   logic [tst_pkg::TAG_W-1:0]       pend_tag_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tst_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [tst_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [tst_pkg::TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            emit;
   logic                            out_free;
   logic                            wr_en;
   tst_pkg::entry_type              wr_entry;
   tst_pkg::entry_type              rd_entry;
   logic [tst_pkg::ENTRY_W-1:0]     rd_data;
   logic [tst_pkg::TIME_W-1:0]      diff;

   assign slot     = cmd.idx[tst_pkg::SLOT_W-1:0];
   assign rd_entry = tst_pkg::entry_type'(rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // wrap-safe due check: now strictly past deadline
   assign diff = now_ff - rd_entry.deadline;

   assign stat.new_is_tick = (req_type == tst_pkg::REQ_TICK);
   assign stat.slot_busy   = valid_ff[slot];
   assign stat.fire        = (diff != '0) && !diff[tst_pkg::TIME_W-1];
   assign stat.out_free    = out_free;
   assign stat.pend_vld    = pend_vld_ff;

   // slot ram writes: new entry on add, deadline reload on periodic fire
   always_comb begin
      wr_en = cmd.add_commit || (cmd.fire_commit && slot_per_ff[slot]);
      if (cmd.add_commit) begin
         wr_entry.deadline = now_ff + tst_pkg::TIME_W'(span_ff);
         wr_entry.span     = span_ff;
         wr_entry.tag      = tag_ff;
      end else begin
         wr_entry.deadline = now_ff + tst_pkg::TIME_W'(rd_entry.span);
         wr_entry.span     = rd_entry.span;
         wr_entry.tag      = rd_entry.tag;
      end
   end

   tst_ram #(
      .WIDTH (tst_pkg::ENTRY_W),
      .DEPTH (tst_pkg::TIMER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (wr_entry),
      .rd_en   (cmd.ram_rd),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // time, slot flags and held fire beat
   always_comb begin
      now_in      = now_ff;
      valid_in    = valid_ff;
      slot_per_in = slot_per_ff;
      pend_vld_in = pend_vld_ff;
      if (cmd.tick_start) begin
         now_in = now_ff + tst_pkg::TIME_W'(1);
      end
      if (cmd.add_commit) begin
         valid_in[slot]    = 1'b1;
         slot_per_in[slot] = periodic_ff;
      end
      if (cmd.fire_commit) begin
         pend_vld_in = 1'b1;
         if (!slot_per_ff[slot]) begin
            valid_in[slot] = 1'b0;
         end
      end
      if (cmd.finish) begin
         pend_vld_in = 1'b0;
      end
   end

   // output beat selection
   always_comb begin
      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.add_commit) begin
         emit        = 1'b1;
         rsp_kind_in = tst_pkg::KIND_ADD_OK;
         rsp_slot_in = tst_pkg::SLOT_OUT_W'(slot);
         rsp_tag_in  = tag_ff;
         rsp_last_in = 1'b1;
      end else if (cmd.emit_full) begin
         emit        = 1'b1;
         rsp_kind_in = tst_pkg::KIND_FULL;
         rsp_slot_in = '0;
         rsp_tag_in  = tag_ff;
         rsp_last_in = 1'b1;
      end else if (cmd.fire_commit && pend_vld_ff) begin
         emit        = 1'b1;
         rsp_kind_in = tst_pkg::KIND_FIRED;
         rsp_slot_in = tst_pkg::SLOT_OUT_W'(pend_idx_ff);
         rsp_tag_in  = pend_tag_ff;
         rsp_last_in = 1'b0;
      end else if (cmd.finish) begin
         emit        = 1'b1;
         rsp_last_in = 1'b1;
         if (pend_vld_ff) begin
            rsp_kind_in = tst_pkg::KIND_FIRED;
            rsp_slot_in = tst_pkg::SLOT_OUT_W'(pend_idx_ff);
            rsp_tag_in  = pend_tag_ff;
         end else begin
            rsp_kind_in = tst_pkg::KIND_QUIET;
            rsp_slot_in = '0;
            rsp_tag_in  = '0;
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         valid_ff     <= '0;
         slot_per_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         valid_ff     <= valid_in;
         slot_per_ff  <= slot_per_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         span_ff     <= req_span_ticks;
         periodic_ff <= req_periodic;
         tag_ff      <= req_timer_tag;
      end
      if (cmd.fire_commit) begin
         pend_idx_ff <= slot;
         pend_tag_ff <= rd_entry.tag;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_fired_tag  = rsp_tag_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== src/timer_slot_table.sv =====
// Timer slot table: holds up to TIMER_SLOTS timers, each with a tag and a span in
// one slot ram with a single read and a single write port, and a periodic flag in a
// register. An add searches the slots from zero, one per cycle, and takes the first
// free one. A tick advances time by one and walks every slot in ascending order: a
// free slot is skipped, an occupied one is read from the slot ram, then due-checked.
// Each fired timer gives one beat, the final beat of a request has last set, and a
// tick where nothing fires gives one quiet beat. One request is worked at a time; the
// next is taken as soon as the final beat sits in the output register, and a stall on
// the result side holds the search or the walk until the output register is free.
module timer_slot_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [tst_pkg::SPAN_W-1:0]        req_span_ticks,
   input  logic                              req_periodic,
   input  logic [tst_pkg::TAG_W-1:0]         req_timer_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tst_pkg::KIND_W-1:0]        rsp_kind,
   output logic [tst_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   output logic [tst_pkg::TAG_W-1:0]         rsp_fired_tag,
   output logic                              rsp_last
);

   tst_pkg::cmd_type  cmd;
   tst_pkg::stat_type stat;

   // sequencing
   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result path
   tst_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_span_ticks (req_span_ticks),
      .req_periodic   (req_periodic),
      .req_timer_tag  (req_timer_tag),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_slot_index (rsp_slot_index),
      .rsp_fired_tag  (rsp_fired_tag),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== src/tst_checker.sv =====
// port-level checks of the timer slot table and their bind
`include "timer_slot_table_defines.svh"

module tst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [tst_pkg::KIND_W-1:0]        rsp_kind,
   input logic [tst_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   input logic [tst_pkg::TAG_W-1:0]         rsp_fired_tag,
   input logic                              rsp_last
);

   // a stalled result beat stays put
   `TST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_slot_index) && $stable(rsp_fired_tag) && $stable(rsp_last))

   // a taken request makes the block busy in the next cycle
   `TST_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

   // only fire beats can be followed by more beats of the same request
   `TST_ASSERT_IMPL(a_single_beat_last, rsp_valid && rsp_kind != tst_pkg::KIND_FIRED, rsp_last)

   // a quiet tick reports slot zero and tag zero
   `TST_ASSERT_IMPL(a_quiet_zero, rsp_valid && rsp_kind == tst_pkg::KIND_QUIET, rsp_slot_index == '0 && rsp_fired_tag == '0)

   // no new request while a fire burst is still open
   `TST_ASSERT_IMPL(a_no_take_mid_burst, rsp_valid && !rsp_last, req_stall)

endmodule

bind timer_slot_table tst_checker u_tst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_slot_index (rsp_slot_index),
   .rsp_fired_tag  (rsp_fired_tag),
   .rsp_last       (rsp_last)
);
